// File: rtl/ulkt_pkg.sv
package ulkt_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int COUNT_W  = $clog2(CAPACITY + 1);

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_DUP     = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] key;
        logic [15:0] entry_handle;
    } request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] found_handle;
        logic [3:0]  position;
        logic [4:0]  entry_count;
    } result_t;

    typedef struct packed {
        logic write;
        logic shift;
    } cell_ctrl_t;

endpackage

// File: rtl/ulkt_cell.sv
module ulkt_cell (
    input  logic                clk,
    input  ulkt_pkg::cell_ctrl_t ctrl,
    input  logic                occupied,
    input  logic [31:0]         cmp_key,
    input  logic [31:0]         new_key,
    input  logic [15:0]         new_handle,
    input  logic [31:0]         next_key,
    input  logic [15:0]         next_handle,
    output logic [31:0]         key,
    output logic [15:0]         handle,
    output logic                match
);
    import ulkt_pkg::*;

    logic [31:0] key_reg;
    logic [31:0] key_next;
    logic [15:0] handle_reg;
    logic [15:0] handle_next;

    always_comb
    begin
        key_next    = key_reg;
        handle_next = handle_reg;
        if (ctrl.write)
        begin
            key_next    = new_key;
            handle_next = new_handle;
        end
        else if (ctrl.shift)
        begin
            key_next    = next_key;
            handle_next = next_handle;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        handle_reg <= handle_next;
    end

    assign key    = key_reg;
    assign handle = handle_reg;
    assign match  = occupied && (key_reg == cmp_key);

endmodule

// File: rtl/unique_key_list_table.sv
// An accepted start loads req_reg and raises busy; done and result are registered
// from the compare that the cells make while busy is high.
// A new command is accepted only while busy is low; busy is high for the one cycle in
// which the cells compare in parallel and then shift or append.
// Reset (rst_n, async, active low) empties the list; cell contents are not
// cleared. The receiver cannot stall: done marks each result for one cycle.
module unique_key_list_table_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  ulkt_pkg::request_t request,
    output logic               busy,
    output logic               done,
    output ulkt_pkg::result_t  result
);
    import ulkt_pkg::*;

    request_t             req_reg;
    logic                 busy_reg;
    logic                 done_reg;
    result_t              result_reg;
    result_t              result_next;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;

    cell_ctrl_t           ctrl     [CAPACITY];
    logic [31:0]          cell_key [CAPACITY];
    logic [15:0]          cell_hdl [CAPACITY];
    logic [CAPACITY-1:0]  match;

    logic                 hit;
    logic [IDX_W-1:0]     hit_pos;
    logic                 do_write;
    logic                 do_shift;
    logic                 full;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic [31:0] nk;
            logic [15:0] nh;
            if (g < CAPACITY - 1)
            begin : g_mid
                assign nk = cell_key[g+1];
                assign nh = cell_hdl[g+1];
            end
            else
            begin : g_last
                assign nk = cell_key[g];
                assign nh = cell_hdl[g];
            end

            assign ctrl[g].write = do_write && (count_reg == COUNT_W'(g));
            assign ctrl[g].shift = do_shift && (hit_pos <= IDX_W'(g));

            ulkt_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl[g]),
                .occupied    (COUNT_W'(g) < count_reg),
                .cmp_key     (req_reg.key),
                .new_key     (req_reg.key),
                .new_handle  (req_reg.entry_handle),
                .next_key    (nk),
                .next_handle (nh),
                .key         (cell_key[g]),
                .handle      (cell_hdl[g]),
                .match       (match[g])
            );
        end
    endgenerate

    // first matching cell wins
    always_comb
    begin
        hit     = 1'b0;
        hit_pos = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit     = 1'b1;
                hit_pos = IDX_W'(i);
            end
        end
    end

    assign full = (count_reg >= COUNT_W'(CAPACITY));

    always_comb
    begin
        do_write    = 1'b0;
        do_shift    = 1'b0;
        count_next  = count_reg;
        result_next = '0;
        result_next.status = ST_MISSING;
        case (req_reg.cmd)
            CMD_INSERT:
            begin
                if (full)
                    result_next.status = ST_FULL;
                else if (hit)
                    result_next.status = ST_DUP;
                else
                begin
                    do_write             = busy_reg;
                    result_next.status   = ST_OK;
                    result_next.position = 4'(count_reg);
                    count_next           = count_reg + 1'b1;
                end
            end
            CMD_LOOKUP:
            begin
                if (hit)
                begin
                    result_next.status       = ST_OK;
                    result_next.position     = 4'(hit_pos);
                    result_next.found_handle = cell_hdl[hit_pos];
                end
            end
            CMD_REMOVE:
            begin
                if (hit)
                begin
                    do_shift                 = busy_reg;
                    result_next.status       = ST_OK;
                    result_next.position     = 4'(hit_pos);
                    result_next.found_handle = cell_hdl[hit_pos];
                    count_next               = count_reg - 1'b1;
                end
            end
            default:
            begin
                result_next.status = ST_MISSING;
            end
        endcase
        result_next.entry_count = 5'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg <= start && !busy_reg;
            done_reg <= busy_reg;
            if (busy_reg)
                count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
            req_reg <= request;
        if (busy_reg)
            result_reg <= result_next;
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without a preceding busy cycle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_single_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("busy held beyond one cycle");

    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.entry_count == 5'(count_reg)))
        else $error("reported count differs from held count");
`endif

endmodule
